>>> rtl/core/dsf_pkg.sv
package dsf_pkg;

   // parser phase, one-hot
   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_DATA   = 3'b010,
      PH_SKIP   = 3'b100
   } phase_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_DATA       = 2'd0,
      KIND_HDR_OK     = 2'd1,
      KIND_HDR_ERROR  = 2'd2
   } kind_type;

   // header error codes
   typedef enum logic [3:0] {
      ERR_TRUNCATED = 4'd0,
      ERR_DSD_ID    = 4'd1,
      ERR_DSD_SIZE  = 4'd2,
      ERR_FMT_ID    = 4'd3,
      ERR_FMT_SIZE  = 4'd4,
      ERR_VERSION   = 4'd5,
      ERR_FORMAT    = 4'd6,
      ERR_CHANNELS  = 4'd7,
      ERR_RATE      = 4'd8,
      ERR_BITS      = 4'd9,
      ERR_BLOCK     = 4'd10,
      ERR_DATA_ID   = 4'd11
   } err_type;

   // header layout
   localparam int HDR_POS_W = 7;
   localparam logic [HDR_POS_W-1:0] POS_DSD_END  = 7'd27;
   localparam logic [HDR_POS_W-1:0] POS_FMT_END  = 7'd79;
   localparam logic [HDR_POS_W-1:0] POS_HDR_LAST = 7'd91;

   // chunk ids, little endian
   localparam logic [31:0] ID_DSD  = 32'h2044_5344;
   localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;

   localparam logic [63:0] DSD_CHUNK_SIZE = 64'd28;
   localparam logic [63:0] FMT_CHUNK_SIZE = 64'd52;

   // sampling rates
   localparam logic [31:0] RATE_DSD64  = 32'd2822400;
   localparam logic [31:0] RATE_DSD128 = 32'd5644800;
   localparam logic [31:0] RATE_DSD256 = 32'd11289600;

   // stored channel count, enough for counts up to eight
   localparam int CCOUNT_W = 4;
   // per-channel byte limit and counters, ceil(2^64 / 8) needs 62 bits
   localparam int LIMIT_W = 62;

endpackage

>>> rtl/core/dsf_stream_header_and_deinterleave.sv
// a result is registered and appears on rsp_ in the cycle after its request is accepted
// throughput: one request per cycle; the single result register with its valid
//   bit is the only holding point, so req_stall follows rsp_stall only while it is full
// reset: synchronous, active high; returns to header phase with no error latched
//   and clears the channel routing state
module dsf_stream_header_and_deinterleave #(
   parameter int MAX_CHANNELS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dsf_pkg::kind_type rsp_kind,
   output logic [2:0]  rsp_channel,
   output logic [7:0]  rsp_data_byte,
   output dsf_pkg::err_type rsp_error_code,
   output logic [2:0]  rsp_channel_count,
   output logic [1:0]  rsp_rate_code,
   output logic [31:0] rsp_block_size,
   output logic [63:0] rsp_sample_count,
   output logic [63:0] rsp_data_chunk_size,
   output logic [63:0] rsp_total_file_size,
   output logic [63:0] rsp_metadata_offset,
   output logic [31:0] rsp_channel_type
);
   import dsf_pkg::*;

   // control state
   phase_type             phase_ff, phase_in;
   logic [HDR_POS_W-1:0]  header_position_ff, header_position_in;
   logic [63:0]           field_shift_ff, field_shift_in;
   logic [2:0]            byte_in_field_ff, byte_in_field_in;
   logic                  err_valid_ff, err_valid_in;
   err_type               err_code_ff, err_code_in;
   logic [31:0]           block_offset_ff, block_offset_in;
   logic [2:0]            current_channel_ff, current_channel_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic [LIMIT_W-1:0]    count_ff [MAX_CHANNELS];
   logic [LIMIT_W-1:0]    count_in [MAX_CHANNELS];

   // captured header fields
   logic [63:0]           total_ff, total_in;
   logic [63:0]           meta_ff, meta_in;
   logic [63:0]           samples_ff, samples_in;
   logic [63:0]           dsize_ff, dsize_in;
   logic [31:0]           ctype_ff, ctype_in;
   logic [CCOUNT_W-1:0]   ccount_ff, ccount_in;
   logic [1:0]            rate_ff, rate_in;
   logic [31:0]           block_ff, block_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, res_kind;
   logic [2:0]            rsp_channel_ff, res_channel;
   logic [7:0]            rsp_data_ff, res_data;
   err_type               rsp_code_ff, res_code;
   logic                  res_hit, res_hdr;

   // per-request working signals
   logic                  req_accept;
   logic [63:0]           shift_in;
   logic [31:0]           word;
   logic                  field_end;
   logic                  chunk_end;
   logic                  flag_hit;
   err_type               flag_code;
   logic                  err_any;
   err_type               err_any_code;
   logic [LIMIT_W-1:0]    sel_count;
   logic                  ch_ok;
   logic [31:0]           offset_inc;
   logic [CCOUNT_W-1:0]   ch_inc;

   // request side holds off only while a finished result is waiting and rsp_stall is high
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // field assembly, little endian
   assign shift_in = field_shift_ff | ({56'd0, req_in_byte} << {byte_in_field_ff, 3'b000});
   assign word     = shift_in[31:0];
   assign chunk_end = (header_position_ff == POS_DSD_END) ||
                      (header_position_ff == POS_FMT_END) ||
                      (header_position_ff == POS_HDR_LAST);

   // field boundaries
   always_comb begin
      case (header_position_ff) inside
         7'd3, 7'd11, 7'd19, 7'd27, 7'd31, 7'd39, 7'd43, 7'd47, 7'd51,
         7'd55, 7'd59, 7'd63, 7'd71, 7'd75, 7'd79, 7'd83, 7'd91: field_end = 1'b1;
         default: field_end = 1'b0;
      endcase
   end

   // field checks and captures
   always_comb begin
      flag_hit   = 1'b0;
      flag_code  = ERR_TRUNCATED;
      total_in   = total_ff;
      meta_in    = meta_ff;
      samples_in = samples_ff;
      dsize_in   = dsize_ff;
      ctype_in   = ctype_ff;
      ccount_in  = ccount_ff;
      rate_in    = rate_ff;
      block_in   = block_ff;
      unique case (header_position_ff)
         7'd3: begin
            flag_hit  = (word != ID_DSD);
            flag_code = ERR_DSD_ID;
         end
         7'd11: begin
            flag_hit  = (shift_in != DSD_CHUNK_SIZE);
            flag_code = ERR_DSD_SIZE;
         end
         7'd19: total_in = shift_in;
         7'd27: meta_in  = shift_in;
         7'd31: begin
            flag_hit  = (word != ID_FMT);
            flag_code = ERR_FMT_ID;
         end
         7'd39: begin
            flag_hit  = (shift_in != FMT_CHUNK_SIZE);
            flag_code = ERR_FMT_SIZE;
         end
         7'd43: begin
            flag_hit  = (word != 32'd1);
            flag_code = ERR_VERSION;
         end
         7'd47: begin
            flag_hit  = (word != 32'd0);
            flag_code = ERR_FORMAT;
         end
         7'd51: ctype_in = word;
         7'd55: begin
            flag_hit  = (word == 32'd0) || (word > 32'(MAX_CHANNELS));
            flag_code = ERR_CHANNELS;
            ccount_in = word[CCOUNT_W-1:0];
         end
         7'd59: begin
            flag_code = ERR_RATE;
            if (word == RATE_DSD64) begin
               rate_in = 2'd0;
            end else if (word == RATE_DSD128) begin
               rate_in = 2'd1;
            end else if (word == RATE_DSD256) begin
               rate_in = 2'd2;
            end else begin
               rate_in  = 2'd0;
               flag_hit = 1'b1;
            end
         end
         7'd63: begin
            flag_hit  = (word != 32'd1);
            flag_code = ERR_BITS;
         end
         7'd71: samples_in = shift_in;
         7'd75: begin
            flag_hit  = (word == 32'd0);
            flag_code = ERR_BLOCK;
            block_in  = word;
         end
         7'd83: begin
            flag_hit  = (word != ID_DATA);
            flag_code = ERR_DATA_ID;
         end
         7'd91: dsize_in = shift_in;
         default: ;
      endcase
   end

   // first error wins
   assign err_any      = err_valid_ff | flag_hit;
   assign err_any_code = err_valid_ff ? err_code_ff : flag_code;

   // byte counter of the current channel
   always_comb begin
      sel_count = '0;
      ch_ok     = 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         if (int'(current_channel_ff) == i) begin
            sel_count = count_ff[i];
            ch_ok     = 1'b1;
         end
      end
   end

   assign offset_inc = block_offset_ff + 32'd1;
   assign ch_inc     = {1'b0, current_channel_ff} + 4'd1;

   // next state and result
   always_comb begin
      phase_in           = phase_ff;
      header_position_in = header_position_ff;
      field_shift_in     = field_shift_ff;
      byte_in_field_in   = byte_in_field_ff;
      err_valid_in       = err_valid_ff;
      err_code_in        = err_code_ff;
      block_offset_in    = block_offset_ff;
      current_channel_in = current_channel_ff;
      limit_in           = limit_ff;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         count_in[i] = count_ff[i];
      end
      res_hit     = 1'b0;
      res_hdr     = 1'b0;
      res_kind    = KIND_DATA;
      res_channel = 3'd0;
      res_data    = 8'd0;
      res_code    = ERR_TRUNCATED;

      if (req_accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               header_position_in = header_position_ff + 7'd1;
               if (field_end) begin
                  field_shift_in   = '0;
                  byte_in_field_in = 3'd0;
               end else begin
                  field_shift_in   = shift_in;
                  byte_in_field_in = byte_in_field_ff + 3'd1;
               end
               err_valid_in = err_any;
               err_code_in  = err_any_code;

               if (chunk_end && err_any) begin
                  res_hit  = 1'b1;
                  res_kind = KIND_HDR_ERROR;
                  res_code = err_any_code;
                  phase_in = PH_SKIP;
               end else if (header_position_ff == POS_HDR_LAST) begin
                  res_hit  = 1'b1;
                  res_hdr  = 1'b1;
                  res_kind = KIND_HDR_OK;
                  for (int i = 0; i < MAX_CHANNELS; i++) begin
                     count_in[i] = '0;
                  end
                  block_offset_in    = '0;
                  current_channel_in = 3'd0;
                  limit_in = {1'b0, samples_ff[63:3]} + LIMIT_W'(|samples_ff[2:0]);
                  phase_in = PH_DATA;
               end else if (req_end_of_file) begin
                  res_hit  = 1'b1;
                  res_kind = KIND_HDR_ERROR;
                  res_code = ERR_TRUNCATED;
               end
            end
            PH_DATA: begin
               if (ch_ok && (sel_count < limit_ff)) begin
                  res_hit     = 1'b1;
                  res_kind    = KIND_DATA;
                  res_channel = current_channel_ff;
                  res_data    = req_in_byte;
                  for (int i = 0; i < MAX_CHANNELS; i++) begin
                     if (int'(current_channel_ff) == i) begin
                        count_in[i] = count_ff[i] + LIMIT_W'(1);
                     end
                  end
               end
               // interleave routing
               if (offset_inc >= block_ff) begin
                  block_offset_in    = '0;
                  current_channel_in = (ch_inc >= ccount_ff) ? 3'd0 : ch_inc[2:0];
               end else begin
                  block_offset_in = offset_inc;
               end
            end
            PH_SKIP: ;
            default: ;
         endcase

         // end of file brings the parser back to a fresh header
         if (req_end_of_file) begin
            phase_in           = PH_HEADER;
            header_position_in = '0;
            field_shift_in     = '0;
            byte_in_field_in   = 3'd0;
            err_valid_in       = 1'b0;
            err_code_in        = ERR_TRUNCATED;
         end
      end

      rsp_valid_in = (rsp_valid_ff & rsp_stall) | (req_accept & res_hit);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_HEADER;
         header_position_ff <= '0;
         field_shift_ff     <= '0;
         byte_in_field_ff   <= 3'd0;
         err_valid_ff       <= 1'b0;
         err_code_ff        <= ERR_TRUNCATED;
         block_offset_ff    <= '0;
         current_channel_ff <= 3'd0;
         limit_ff           <= '0;
         rsp_valid_ff       <= 1'b0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         phase_ff           <= phase_in;
         header_position_ff <= header_position_in;
         field_shift_ff     <= field_shift_in;
         byte_in_field_ff   <= byte_in_field_in;
         err_valid_ff       <= err_valid_in;
         err_code_ff        <= err_code_in;
         block_offset_ff    <= block_offset_in;
         current_channel_ff <= current_channel_in;
         limit_ff           <= limit_in;
         rsp_valid_ff       <= rsp_valid_in;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   // captured header fields, written only by header bytes
   always_ff @(posedge clock) begin
      if (req_accept && (phase_ff == PH_HEADER)) begin
         total_ff   <= total_in;
         meta_ff    <= meta_in;
         samples_ff <= samples_in;
         dsize_ff   <= dsize_in;
         ctype_ff   <= ctype_in;
         ccount_ff  <= ccount_in;
         rate_ff    <= rate_in;
         block_ff   <= block_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_accept && res_hit) begin
         rsp_kind_ff         <= res_kind;
         rsp_channel_ff      <= res_channel;
         rsp_data_ff         <= res_data;
         rsp_code_ff         <= res_code;
         rsp_channel_count   <= res_hdr ? ccount_in[2:0] : 3'd0;
         rsp_rate_code       <= res_hdr ? rate_in : 2'd0;
         rsp_block_size      <= res_hdr ? block_in : 32'd0;
         rsp_sample_count    <= res_hdr ? samples_in : 64'd0;
         rsp_data_chunk_size <= res_hdr ? dsize_in : 64'd0;
         rsp_total_file_size <= res_hdr ? total_in : 64'd0;
         rsp_metadata_offset <= res_hdr ? meta_in : 64'd0;
         rsp_channel_type    <= res_hdr ? ctype_in : 32'd0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_channel    = rsp_channel_ff;
   assign rsp_data_byte  = rsp_data_ff;
   assign rsp_error_code = rsp_code_ff;

   // routing stays inside the configured channels
   a_chan_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> ({1'b0, current_channel_ff} < ccount_ff))
      else $error("current channel beyond channel count");

   // block offset never reaches the block size
   a_offset_in_block: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (block_offset_ff < block_ff))
      else $error("block offset out of range");

   // data phase is only entered with a clean header
   a_data_no_error: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> !err_valid_ff)
      else $error("data phase with a latched header error");

   // end of file restarts header capture
   a_eof_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_end_of_file) |=>
         (phase_ff == PH_HEADER) && (header_position_ff == '0) && !err_valid_ff)
      else $error("end of file did not restart header");

   // a data result carries a routed channel below the channel limit
   a_data_channel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_DATA)) |-> (int'(rsp_channel_ff) < MAX_CHANNELS))
      else $error("data result on an invalid channel");

endmodule
